@@ rtl/tdf_pkg.sv @@
// ----------------------------------------------------------------------------
// tdf_pkg: shared types and constants of the trial division factorizer
// Widths, result kinds, controller states and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

   localparam int VALUE_BITS   = 32;
   localparam int IN_BITS      = 32;
   localparam int PRIME_BITS   = 32;
   localparam int EXP_BITS     = 6;
   localparam int MAX_RESULTS  = 9;
   localparam int COUNT_BITS   = $clog2(MAX_RESULTS + 1);
   localparam int DIV_CNT_BITS = $clog2(VALUE_BITS);

   typedef enum logic [1:0] {
      KIND_FACTOR = 2'd0,
      KIND_ONE    = 2'd1,
      KIND_ZERO   = 2'd2
   } kind_type;

   typedef enum logic {
      SRC_DIVISOR = 1'b0,
      SRC_REST    = 1'b1
   } emit_src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_START,
      ST_WAIT,
      ST_EMIT_ZERO,
      ST_EMIT_ONE,
      ST_EMIT_ROOT,
      ST_EMIT_DIV
   } state_type;

   typedef struct packed {
      logic         load;
      logic         div_start;
      logic         take_quot;
      logic         next_div;
      logic         emit;
      emit_src_type src;
      kind_type     kind;
      logic         last;
   } cmd_type;

   typedef struct packed {
      logic rest_zero;
      logic rest_one;
      logic div_done;
      logic d_gt_q;
      logic rem_zero;
      logic expo_nz;
      logic count_full;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/tdf_div.sv @@
// ----------------------------------------------------------------------------
// tdf_div: restoring divider
// Produces quotient and remainder one bit per cycle once started, and flags
// completion with a single-cycle done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_div
   import tdf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [VALUE_BITS-1:0] dividend,
   input  wire logic [VALUE_BITS-1:0] divisor,
   output logic                       done,
   output logic [VALUE_BITS-1:0]      quotient,
   output logic [VALUE_BITS-1:0]      remainder
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0]   quot_ff, quot_in;
   logic [VALUE_BITS-1:0]   rem_ff, rem_in;
   logic [VALUE_BITS:0]     rem_shift;
   logic [VALUE_BITS:0]     rem_diff;
   logic                    fits;

   assign rem_shift = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor};
   assign fits      = rem_shift >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[VALUE_BITS-2:0], fits};
         rem_in  = fits ? rem_diff[VALUE_BITS-1:0] : rem_shift[VALUE_BITS-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ rtl/tdf_dpath.sv @@
// ----------------------------------------------------------------------------
// tdf_dpath: factorizer datapath
// Holds the remaining cofactor, trial divisor, exponent and result count,
// drives the divider and owns the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_dpath
   import tdf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [IN_BITS-1:0]    in_value,
   output logic                       out_valid,
   input  wire logic                  out_stall,
   output logic [PRIME_BITS-1:0]      out_prime,
   output logic [EXP_BITS-1:0]        out_exponent,
   output logic [1:0]                 out_kind,
   output logic                       out_last
);

   logic [VALUE_BITS-1:0] rest_ff, rest_in;
   logic [VALUE_BITS-1:0] divisor_ff, divisor_in;
   logic [EXP_BITS-1:0]   expo_ff, expo_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PRIME_BITS-1:0] rsp_prime_ff, rsp_prime_in;
   logic [EXP_BITS-1:0]   rsp_expo_ff, rsp_expo_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quot;
   logic [VALUE_BITS-1:0] div_rem;
   logic                  out_free;

   tdf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (rest_ff),
      .divisor   (divisor_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign out_free = !rsp_valid_ff || !out_stall;

   always_comb begin
      rest_in      = rest_ff;
      divisor_in   = divisor_ff;
      expo_in      = expo_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && out_stall;
      rsp_prime_in = rsp_prime_ff;
      rsp_expo_in  = rsp_expo_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.load) begin
         rest_in    = in_value[VALUE_BITS-1:0];
         divisor_in = VALUE_BITS'(2);
         expo_in    = '0;
         count_in   = '0;
      end
      if (cmd.take_quot) begin
         rest_in = div_quot;
         expo_in = expo_ff + 1'b1;
      end
      if (cmd.next_div) begin
         // two is followed by three, then odd steps
         divisor_in = (divisor_ff == VALUE_BITS'(2)) ? VALUE_BITS'(3)
                                                     : divisor_ff + VALUE_BITS'(2);
         expo_in    = '0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = cmd.kind;
         rsp_last_in  = cmd.last;
         count_in     = count_ff + 1'b1;
         if (cmd.kind != KIND_FACTOR) begin
            rsp_prime_in = '0;
            rsp_expo_in  = '0;
         end else if (cmd.src == SRC_REST) begin
            rsp_prime_in = PRIME_BITS'(rest_ff);
            rsp_expo_in  = EXP_BITS'(1);
         end else begin
            rsp_prime_in = PRIME_BITS'(divisor_ff);
            rsp_expo_in  = expo_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         divisor_ff   <= VALUE_BITS'(2);
         expo_ff      <= '0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         divisor_ff   <= divisor_in;
         expo_ff      <= expo_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff      <= rest_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_expo_ff  <= rsp_expo_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.rest_zero  = rest_ff == '0;
   assign status.rest_one   = rest_ff == VALUE_BITS'(1);
   assign status.div_done   = div_done;
   assign status.d_gt_q     = divisor_ff > div_quot;
   assign status.rem_zero   = div_rem == '0;
   assign status.expo_nz    = expo_ff != '0;
   assign status.count_full = count_ff == COUNT_BITS'(MAX_RESULTS - 1);
   assign status.out_free   = out_free;

   assign out_valid    = rsp_valid_ff;
   assign out_prime    = rsp_prime_ff;
   assign out_exponent = rsp_expo_ff;
   assign out_kind     = rsp_kind_ff;
   assign out_last     = rsp_last_ff;

   a_divisor_two_or_odd: assert property (@(posedge clock) disable iff (reset)
      divisor_ff == VALUE_BITS'(2) || divisor_ff[0])
      else $error("trial divisor is even and not two");

   a_special_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != KIND_FACTOR |-> rsp_last_ff)
      else $error("one or zero result without last flag");

   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result written over a waiting result");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      div_done |=> !div_done)
      else $error("divider done held for more than one cycle");

endmodule

`default_nettype wire

@@ rtl/tdf_ctrl.sv @@
// ----------------------------------------------------------------------------
// tdf_ctrl: factorizer controller
// Sequences request capture, trial divisions, divisor steps and result
// writes, driving the datapath by command and reading its status.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_ctrl
   import tdf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_stall,
   output cmd_type         cmd,
   input  wire status_type status
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.src  = SRC_DIVISOR;
      cmd.kind = KIND_FACTOR;
      in_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            in_stall = 1'b0;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (status.rest_zero) begin
               state_in = ST_EMIT_ZERO;
            end else if (status.rest_one) begin
               state_in = ST_EMIT_ONE;
            end else begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.div_done) begin
               // first division by a new divisor also settles the square bound
               priority if (!status.expo_nz && status.d_gt_q) begin
                  state_in = ST_EMIT_ROOT;
               end else if (status.rem_zero) begin
                  cmd.take_quot = 1'b1;
                  state_in      = ST_START;
               end else if (status.expo_nz) begin
                  state_in = ST_EMIT_DIV;
               end else begin
                  cmd.next_div = 1'b1;
                  state_in     = ST_START;
               end
            end
         end
         ST_EMIT_ZERO: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_ZERO;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_ONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_ONE;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_ROOT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_REST;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_DIV: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = status.rest_one || status.count_full;
               if (status.rest_one || status.count_full) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_div = 1'b1;
                  state_in     = ST_START;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/trial_division_factorizer.sv @@
// ----------------------------------------------------------------------------
// trial_division_factorizer: prime factorization by trial division
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// One request is factored at a time; the next is taken once the last result
// of the current one has gone into the output register. Every trial division
// runs through one shared restoring divider at one quotient bit per cycle;
// each division is a start, one step per quotient bit and a done pulse.
// A value costs one division for each divisor tried and one more for each
// time a prime is divided out, plus a write per result and the capture and
// check of the request; the worst case is a large prime, which forces some
// 32768 odd trial divisors. Results come out in ascending prime order, one
// per distinct prime, and the final one carries rsp_last; zero and one each
// give a single special result.
`default_nettype none

module trial_division_factorizer
   import tdf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [IN_BITS-1:0]    req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [PRIME_BITS-1:0]      rsp_prime,
   output logic [EXP_BITS-1:0]        rsp_exponent,
   output logic [1:0]                 rsp_kind,
   output logic                       rsp_last
);

   cmd_type    cmd;
   status_type status;

   tdf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .cmd      (cmd),
      .status   (status)
   );

   tdf_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_value     (req_value),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_prime    (rsp_prime),
      .out_exponent (rsp_exponent),
      .out_kind     (rsp_kind),
      .out_last     (rsp_last)
   );

endmodule

`default_nettype wire

@@ dv/factor_checker.sv @@
// ----------------------------------------------------------------------------
// factor_checker: result checker for the trial division factorizer
// Watches both channels, works out the prime factors of every accepted
// request and compares each accepted result with the oldest one still owed.
// ----------------------------------------------------------------------------
module factor_checker
   import tdf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [IN_BITS-1:0]    req_value,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [PRIME_BITS-1:0] rsp_prime,
   input  wire logic [EXP_BITS-1:0]   rsp_exponent,
   input  wire logic [1:0]            rsp_kind,
   input  wire logic                  rsp_last,
   output int                         mismatches,
   output int                         factors_owed
);

   typedef struct packed {
      logic [PRIME_BITS-1:0] prime;
      logic [EXP_BITS-1:0]   exponent;
      kind_type              kind;
      logic                  last;
   } factor_rec;

   factor_rec factors_due [$];

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // split one request into its prime factors, smallest first
   task automatic push_factors(input logic [IN_BITS-1:0] value);
      logic [63:0]         rest;
      logic [63:0]         divisor;
      logic [EXP_BITS-1:0] mult;
      factor_rec           found [MAX_RESULTS];
      int                  n;
      rest = 64'(value) & ((64'd1 << VALUE_BITS) - 64'd1);
      n = 0;
      if (rest == 64'd0) begin
         found[0] = '{prime: '0, exponent: '0, kind: KIND_ZERO, last: 1'b1};
         n = 1;
      end else if (rest == 64'd1) begin
         found[0] = '{prime: '0, exponent: '0, kind: KIND_ONE, last: 1'b1};
         n = 1;
      end else begin
         divisor = 64'd2;
         while (rest > 64'd1 && n < MAX_RESULTS) begin
            if (divisor > rest / divisor) begin
               // what is left has no divisor up to its root, so it is prime
               found[n] = '{prime: PRIME_BITS'(rest), exponent: EXP_BITS'(1),
                            kind: KIND_FACTOR, last: 1'b0};
               n++;
               rest = 64'd1;
            end else begin
               mult = '0;
               while (rest % divisor == 64'd0) begin
                  rest = rest / divisor;
                  mult++;
               end
               if (mult != '0) begin
                  found[n] = '{prime: PRIME_BITS'(divisor), exponent: mult,
                               kind: KIND_FACTOR, last: 1'b0};
                  n++;
               end
               divisor = (divisor == 64'd2) ? 64'd3 : divisor + 64'd2;
            end
         end
         found[n-1].last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         factors_due = {factors_due, found[i]};
      end
   endtask

   always @(posedge clock) begin : watch
      factor_rec want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (factors_due.size() == 0) begin
               report_mismatch($sformatf("result with nothing owed, prime %0d", rsp_prime));
            end else begin
               want = factors_due.pop_front();
               if (rsp_prime !== want.prime)
                  report_mismatch($sformatf("prime %0d, want %0d", rsp_prime, want.prime));
               if (rsp_exponent !== want.exponent)
                  report_mismatch($sformatf("exponent %0d, want %0d",
                                            rsp_exponent, want.exponent));
               if (rsp_kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, want %0b", rsp_last, want.last));
            end
         end
         if (req_valid && !req_stall) begin
            push_factors(req_value);
         end
      end
      factors_owed <= factors_due.size();
   end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench top for the trial division factorizer
// Sends corner values, then random values built mostly from small primes so
// that each factorization stays short, idling both channels at random until the last 20.
// ----------------------------------------------------------------------------
module tb;
   import tdf_pkg::*;

   localparam int CYCLE_LIMIT   = 5_000_000;
   localparam int RANDOM_ITEMS  = 100;
   localparam int SETTLE_CYCLES = 100;
   localparam int NUM_CORNERS   = 19;

   localparam logic [IN_BITS-1:0] CORNER_VALUES [NUM_CORNERS] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd1, 32'd0, 32'd6,
      32'hFFFF_FFFF,       // 3 * 5 * 17 * 257 * 65537
      32'h8000_0000,       // highest power of two
      32'h5555_5555,
      32'hAAAA_AAAA,
      32'd3486784401,      // 3 to the 20th
      32'd223092870,       // nine distinct primes, the most that fit
      32'd4238764530,      // nine primes with 19 squared
      32'd4294966528,      // 256 times the largest prime below 2 to the 24th
      32'd65537,
      32'd4294836225,      // 65535 squared
      32'd9409             // 97 squared
   };

   localparam int unsigned SMALL_PRIMES [25] = '{
      2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
      53, 59, 61, 67, 71, 73, 79, 83, 89, 97
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [IN_BITS-1:0]    req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PRIME_BITS-1:0] rsp_prime;
   logic [EXP_BITS-1:0]   rsp_exponent;
   logic [1:0]            rsp_kind;
   logic                  rsp_last;

   int mismatches;
   int factors_owed;
   int idle_odds = 4;       // one chance in this many of a burst, zero for none
   int stall_left = 0;

   always #6 clock = ~clock;

   trial_division_factorizer uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_prime    (rsp_prime),
      .rsp_exponent (rsp_exponent),
      .rsp_kind     (rsp_kind),
      .rsp_last     (rsp_last)
   );

   factor_checker factor_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_prime    (rsp_prime),
      .rsp_exponent (rsp_exponent),
      .rsp_kind     (rsp_kind),
      .rsp_last     (rsp_last),
      .mismatches   (mismatches),
      .factors_owed (factors_owed)
   );

   // result side holds off in bursts
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
         stall_left <= $urandom_range(1, 12) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // mostly smooth values with at most one cofactor below 2 to the 16th,
   // which keeps the trial divisors under a few hundred
   function automatic logic [IN_BITS-1:0] random_value();
      logic [63:0] acc;
      logic [63:0] m;
      int          picks;
      case ($urandom_range(0, 9))
         0: acc = 64'($urandom_range(0, 1023));
         1: acc = 64'($urandom_range(0, 1 << 20));
         default: begin
            acc = 64'd1;
            picks = $urandom_range(1, 12);
            repeat (picks) begin
               m = 64'(SMALL_PRIMES[$urandom_range(0, 24)]);
               if (acc * m <= 64'hFFFF_FFFF) acc = acc * m;
            end
            if ($urandom_range(0, 1) == 1) begin
               m = 64'($urandom_range(2, 65535));
               if (acc * m <= 64'hFFFF_FFFF) acc = acc * m;
            end
         end
      endcase
      return acc[IN_BITS-1:0];
   endfunction

   task automatic send_value(input logic [IN_BITS-1:0] v);
      int gap;
      if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb failed");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (CORNER_VALUES[i]) begin
         send_value(CORNER_VALUES[i]);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idle_odds = (i < 40) ? 3 : (i < 80) ? 8 : 0;
         send_value(random_value());
      end
      req_valid <= 1'b0;
      do @(negedge clock); while (factors_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
